>>> sv/wgs_pkg.sv
`default_nettype none

package wgs_pkg;

  // vector components per state vector
  localparam int NUM_AXES = 3;
  localparam logic [1:0] LAST_IDX = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_TARGET_X   = 3'd0;
  localparam logic [2:0] CFG_TARGET_Y   = 3'd1;
  localparam logic [2:0] CFG_TARGET_Z   = 3'd2;
  localparam logic [2:0] CFG_MAX_ACCEL  = 3'd3;
  localparam logic [2:0] CFG_ARRIVE_RAD = 3'd4;

  // reset values of the configuration registers
  localparam logic [31:0] RST_TARGET_X   = 32'sd655360;
  localparam logic [31:0] RST_TARGET_Y   = -32'sd6553600;
  localparam logic [31:0] RST_TARGET_Z   = 32'sd6553600;
  localparam logic [30:0] RST_MAX_ACCEL  = 31'd655360;
  localparam logic [30:0] RST_ARRIVE_RAD = 31'd131072;

  localparam logic signed [33:0] SAT_MAX = 34'sh0_7FFF_FFFF;
  localparam logic signed [33:0] SAT_MIN = 34'sh3_8000_0000;

  // datapath operations, one per controller cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_DEN,
    OP_DEN_SET,
    OP_BRK_GO,
    OP_BRK_SET,
    OP_SQ,
    OP_ACC,
    OP_SAVE,
    OP_REP_CMP,
    OP_DIFF,
    OP_ARR,
    OP_ERR,
    OP_SQRT_GO,
    OP_SQRT_SET,
    OP_AC_MUL,
    OP_AC_GO,
    OP_AC_SET,
    OP_IV_MUL,
    OP_IV_UPD,
    OP_IP_MUL,
    OP_IP_UPD,
    OP_OUT
  } op_t;

  // operand of a squaring step
  typedef enum logic [2:0] {
    SRC_BRK,
    SRC_REP,
    SRC_TMP,
    SRC_VEL,
    SRC_AR
  } sq_src_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] idx;
    sq_src_t    src;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic arrived;
    logic n_zero;
  } dp_stat_t;

  // magnitude of a two's complement word
  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (32'd0 - v) : v;
  endfunction

  // apply sign to a magnitude, saturate to 32 bits
  function automatic logic [31:0] signed_from(input logic neg, input logic [63:0] m);
    if (neg) begin
      if (m >= 64'h0000_0000_8000_0000) signed_from = 32'h8000_0000;
      else signed_from = 32'd0 - m[31:0];
    end else begin
      if (m > 64'h0000_0000_7FFF_FFFF) signed_from = 32'h7FFF_FFFF;
      else signed_from = m[31:0];
    end
  endfunction

  // clamp a widened sum into 32 bits
  function automatic logic [31:0] sat34(input logic signed [33:0] v);
    if (v > SAT_MAX) sat34 = 32'h7FFF_FFFF;
    else if (v < SAT_MIN) sat34 = 32'h8000_0000;
    else sat34 = v[31:0];
  endfunction

endpackage

`default_nettype wire

>>> sv/wgs_div.sv
`default_nettype none

module wgs_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [47:0] divisor,
  output logic [63:0]      quot,
  output logic             done
);

  logic [63:0] q_r;
  logic [47:0] rem_r;
  logic [47:0] dvs_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [48:0] rem_sh;
  logic        ge;
  logic [48:0] rem_sub;

  // one quotient bit per cycle, restoring
  assign rem_sh  = {rem_r, q_r[63]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // shift quotient and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= 48'd0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sub[47:0] : rem_sh[47:0];
      q_r   <= {q_r[62:0], ge};
    end
  end

  assign quot = q_r;
  assign done = done_r;

endmodule

`default_nettype wire

>>> sv/wgs_sqrt.sv
`default_nettype none

module wgs_sqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] radicand,
  output logic [31:0]      root,
  output logic             done
);

  logic [63:0] x_r;
  logic [63:0] r_r;
  logic [63:0] bit_r;
  logic        busy_r;
  logic        done_r;
  logic [63:0] trial;
  logic        ge;

  // one root bit per cycle
  assign trial = r_r + bit_r;
  assign ge    = x_r >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && bit_r[0]) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= radicand;
      r_r   <= 64'd0;
      bit_r <= 64'h4000_0000_0000_0000;
    end else if (busy_r) begin
      x_r   <= ge ? (x_r - trial) : x_r;
      r_r   <= ge ? ((r_r >> 1) + bit_r) : (r_r >> 1);
      bit_r <= bit_r >> 2;
    end
  end

  assign root = r_r[31:0];
  assign done = done_r;

endmodule

`default_nettype wire

>>> sv/wgs_dp.sv
`default_nettype none

module wgs_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire wgs_pkg::dp_cmd_t  cmd,
  output wgs_pkg::dp_stat_t      stat,
  input  wire logic [16:0]       in_step_dt,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [31:0]       cfg_data,
  output logic signed [31:0]     out_pos_x,
  output logic signed [31:0]     out_pos_y,
  output logic signed [31:0]     out_pos_z,
  output logic signed [31:0]     out_acc_x,
  output logic signed [31:0]     out_acc_y,
  output logic signed [31:0]     out_acc_z,
  output logic                   out_arrived
);

  // configuration
  logic [31:0] tgt_r [wgs_pkg::NUM_AXES];
  logic [30:0] max_accel_r;
  logic [30:0] arrive_rad_r;

  // motion state
  logic [31:0] pos_r [wgs_pkg::NUM_AXES];
  logic [31:0] vel_r [wgs_pkg::NUM_AXES];
  logic [31:0] rep_r [wgs_pkg::NUM_AXES];

  // per step work registers
  logic [31:0] brk_r [wgs_pkg::NUM_AXES];
  logic [31:0] err_r [wgs_pkg::NUM_AXES];
  logic [31:0] acc_r [wgs_pkg::NUM_AXES];
  logic [16:0] dt_r;
  logic [47:0] den_r;
  logic [63:0] prod_r;
  logic [63:0] sum_r;
  logic [63:0] hold_r;
  logic [31:0] tmp_r;
  logic [31:0] n_r;
  logic        arrived_r;

  logic [31:0] out_pos_r [wgs_pkg::NUM_AXES];
  logic [31:0] out_acc_r [wgs_pkg::NUM_AXES];
  logic        out_arr_r;

  logic [1:0]  idx;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] sq_val;
  logic        div_start;
  logic [63:0] div_num;
  logic [47:0] div_dvs;
  logic [63:0] div_q;
  logic        div_done;
  logic [31:0] root;
  logic        sqrt_done;
  logic [31:0] diff_v;
  logic [31:0] err_v;
  logic [31:0] dv_step;
  logic [31:0] dp_step;
  logic        arr_now;

  assign idx = cmd.idx;

  // squaring operand
  always_comb begin
    case (cmd.src)
      wgs_pkg::SRC_BRK: sq_val = wgs_pkg::mag32(brk_r[idx]);
      wgs_pkg::SRC_REP: sq_val = wgs_pkg::mag32(rep_r[idx]);
      wgs_pkg::SRC_TMP: sq_val = wgs_pkg::mag32(tmp_r);
      wgs_pkg::SRC_VEL: sq_val = wgs_pkg::mag32(vel_r[idx]);
      wgs_pkg::SRC_AR:  sq_val = {1'b0, arrive_rad_r};
      default:          sq_val = 32'd0;
    endcase
  end

  // shared multiplier operands
  always_comb begin
    case (cmd.op)
      wgs_pkg::OP_DEN: begin
        mul_a = {1'b0, max_accel_r};
        mul_b = {15'd0, dt_r};
      end
      wgs_pkg::OP_SQ: begin
        mul_a = sq_val;
        mul_b = sq_val;
      end
      wgs_pkg::OP_AC_MUL: begin
        mul_a = wgs_pkg::mag32(err_r[idx]);
        mul_b = {1'b0, max_accel_r};
      end
      wgs_pkg::OP_IV_MUL: begin
        mul_a = wgs_pkg::mag32(acc_r[idx]);
        mul_b = {15'd0, dt_r};
      end
      wgs_pkg::OP_IP_MUL: begin
        mul_a = wgs_pkg::mag32(vel_r[idx]);
        mul_b = {15'd0, dt_r};
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  // divider feed: braking quotient or acceleration rescale
  assign div_start = (cmd.op == wgs_pkg::OP_BRK_GO) || (cmd.op == wgs_pkg::OP_AC_GO);
  assign div_num   = (cmd.op == wgs_pkg::OP_BRK_GO)
                   ? {wgs_pkg::mag32(vel_r[idx]), 32'd0} : prod_r;
  assign div_dvs   = (cmd.op == wgs_pkg::OP_BRK_GO) ? den_r : {16'd0, n_r};

  wgs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_dvs),
    .quot     (div_q),
    .done     (div_done)
  );

  wgs_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.op == wgs_pkg::OP_SQRT_GO),
    .radicand (sum_r),
    .root     (root),
    .done     (sqrt_done)
  );

  // distance and error components, saturated
  assign diff_v = wgs_pkg::sat34($signed({{2{tgt_r[idx][31]}}, tgt_r[idx]})
                                - $signed({{2{pos_r[idx][31]}}, pos_r[idx]}));
  assign err_v  = wgs_pkg::sat34($signed({{2{tgt_r[idx][31]}}, tgt_r[idx]})
                                - $signed({{2{pos_r[idx][31]}}, pos_r[idx]})
                                - $signed({{2{rep_r[idx][31]}}, rep_r[idx]}));

  // scaled increments from the last product
  assign dv_step = wgs_pkg::signed_from(acc_r[idx][31], {16'd0, prod_r[63:16]});
  assign dp_step = wgs_pkg::signed_from(vel_r[idx][31], {16'd0, prod_r[63:16]});

  assign arr_now = (hold_r < prod_r) && (sum_r < prod_r);

  // configuration and motion state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r[0]     <= wgs_pkg::RST_TARGET_X;
      tgt_r[1]     <= wgs_pkg::RST_TARGET_Y;
      tgt_r[2]     <= wgs_pkg::RST_TARGET_Z;
      max_accel_r  <= wgs_pkg::RST_MAX_ACCEL;
      arrive_rad_r <= wgs_pkg::RST_ARRIVE_RAD;
      for (int i = 0; i < wgs_pkg::NUM_AXES; i++) begin
        pos_r[i] <= 32'd0;
        vel_r[i] <= 32'd0;
        rep_r[i] <= 32'd0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          wgs_pkg::CFG_TARGET_X:   tgt_r[0]     <= cfg_data;
          wgs_pkg::CFG_TARGET_Y:   tgt_r[1]     <= cfg_data;
          wgs_pkg::CFG_TARGET_Z:   tgt_r[2]     <= cfg_data;
          wgs_pkg::CFG_MAX_ACCEL:  max_accel_r  <= cfg_data[30:0];
          wgs_pkg::CFG_ARRIVE_RAD: arrive_rad_r <= cfg_data[30:0];
          default: ;
        endcase
      end
      case (cmd.op)
        wgs_pkg::OP_REP_CMP: begin
          if (hold_r > sum_r) begin
            for (int i = 0; i < wgs_pkg::NUM_AXES; i++) rep_r[i] <= brk_r[i];
          end
        end
        wgs_pkg::OP_ARR: begin
          if (arr_now) begin
            for (int i = 0; i < wgs_pkg::NUM_AXES; i++) rep_r[i] <= 32'd0;
          end
        end
        wgs_pkg::OP_IV_UPD: vel_r[idx] <= wgs_pkg::sat34($signed({{2{vel_r[idx][31]}}, vel_r[idx]})
                                         + $signed({{2{dv_step[31]}}, dv_step}));
        wgs_pkg::OP_IP_UPD: pos_r[idx] <= wgs_pkg::sat34($signed({{2{pos_r[idx][31]}}, pos_r[idx]})
                                         + $signed({{2{dp_step[31]}}, dp_step}));
        default: ;
      endcase
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      wgs_pkg::OP_LOAD: begin
        dt_r  <= in_step_dt;
        sum_r <= 64'd0;
      end
      wgs_pkg::OP_DEN_SET: den_r <= prod_r[47:0];
      wgs_pkg::OP_BRK_SET: begin
        brk_r[idx] <= (vel_r[idx] == 32'd0) ? 32'd0
                    : wgs_pkg::signed_from(vel_r[idx][31], div_q);
      end
      wgs_pkg::OP_ACC: sum_r <= sum_r + prod_r;
      wgs_pkg::OP_SAVE: begin
        hold_r <= sum_r;
        sum_r  <= 64'd0;
      end
      wgs_pkg::OP_REP_CMP: sum_r <= 64'd0;
      wgs_pkg::OP_DIFF: tmp_r <= diff_v;
      wgs_pkg::OP_ARR: begin
        arrived_r <= arr_now;
        sum_r     <= 64'd0;
        if (arr_now) begin
          for (int i = 0; i < wgs_pkg::NUM_AXES; i++) acc_r[i] <= 32'd0;
        end
      end
      wgs_pkg::OP_ERR: begin
        tmp_r      <= err_v;
        err_r[idx] <= err_v;
      end
      wgs_pkg::OP_SQRT_SET: begin
        n_r <= root;
        for (int i = 0; i < wgs_pkg::NUM_AXES; i++) acc_r[i] <= 32'd0;
      end
      wgs_pkg::OP_AC_SET: acc_r[idx] <= wgs_pkg::signed_from(err_r[idx][31], div_q);
      wgs_pkg::OP_OUT: begin
        for (int i = 0; i < wgs_pkg::NUM_AXES; i++) begin
          out_pos_r[i] <= pos_r[i];
          out_acc_r[i] <= acc_r[i];
        end
        out_arr_r <= arrived_r;
      end
      default: ;
    endcase
    // products are registered, landing in the cycle after their operands
    if (cmd.op == wgs_pkg::OP_DEN || cmd.op == wgs_pkg::OP_SQ
        || cmd.op == wgs_pkg::OP_AC_MUL || cmd.op == wgs_pkg::OP_IV_MUL
        || cmd.op == wgs_pkg::OP_IP_MUL) begin
      prod_r <= {32'd0, mul_a} * {32'd0, mul_b};
    end
  end

  assign stat.div_done  = div_done;
  assign stat.sqrt_done = sqrt_done;
  assign stat.arrived   = arrived_r;
  assign stat.n_zero    = (n_r == 32'd0);

  assign out_pos_x   = out_pos_r[0];
  assign out_pos_y   = out_pos_r[1];
  assign out_pos_z   = out_pos_r[2];
  assign out_acc_x   = out_acc_r[0];
  assign out_acc_y   = out_acc_r[1];
  assign out_acc_z   = out_acc_r[2];
  assign out_arrived = out_arr_r;

endmodule

`default_nettype wire

>>> sv/wgs_ctrl.sv
`default_nettype none

module wgs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire wgs_pkg::dp_stat_t stat,
  output wgs_pkg::dp_cmd_t       cmd
);

  typedef enum logic [5:0] {
    S_IDLE, S_DEN, S_DEN_SET,
    S_BRK_GO, S_BRK_WAIT, S_BRK_SET,
    S_NB_SQ, S_NB_ACC, S_NB_SAVE, S_NR_SQ, S_NR_ACC, S_REP_CMP,
    S_DF_SUB, S_DF_SQ, S_DF_ACC, S_DF_SAVE, S_NV_SQ, S_NV_ACC,
    S_AR_SQ, S_ARR, S_BR,
    S_ER_SUB, S_ER_SQ, S_ER_ACC, S_SQ_GO, S_SQ_WAIT, S_SQ_SET, S_NZ,
    S_AC_MUL, S_AC_GO, S_AC_WAIT, S_AC_SET,
    S_IV_MUL, S_IV_UPD, S_IP_MUL, S_IP_UPD, S_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       last;

  assign last = (idx_r == wgs_pkg::LAST_IDX);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r & out_stall;
    cmd.op        = wgs_pkg::OP_NONE;
    cmd.idx       = idx_r;
    cmd.src       = wgs_pkg::SRC_BRK;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = wgs_pkg::OP_LOAD;
          state_nxt = S_DEN;
        end
      end
      S_DEN: begin
        cmd.op    = wgs_pkg::OP_DEN;
        state_nxt = S_DEN_SET;
      end
      S_DEN_SET: begin
        cmd.op    = wgs_pkg::OP_DEN_SET;
        idx_nxt   = 2'd0;
        state_nxt = S_BRK_GO;
      end
      // braking vector, one divide per axis
      S_BRK_GO: begin
        cmd.op    = wgs_pkg::OP_BRK_GO;
        state_nxt = S_BRK_WAIT;
      end
      S_BRK_WAIT: if (stat.div_done) state_nxt = S_BRK_SET;
      S_BRK_SET: begin
        cmd.op    = wgs_pkg::OP_BRK_SET;
        idx_nxt   = last ? 2'd0 : idx_r + 2'd1;
        state_nxt = last ? S_NB_SQ : S_BRK_GO;
      end
      // squared norms of braking and repulsion
      S_NB_SQ: begin
        cmd.op    = wgs_pkg::OP_SQ;
        cmd.src   = wgs_pkg::SRC_BRK;
        state_nxt = S_NB_ACC;
      end
      S_NB_ACC: begin
        cmd.op    = wgs_pkg::OP_ACC;
        idx_nxt   = last ? 2'd0 : idx_r + 2'd1;
        state_nxt = last ? S_NB_SAVE : S_NB_SQ;
      end
      S_NB_SAVE: begin
        cmd.op    = wgs_pkg::OP_SAVE;
        state_nxt = S_NR_SQ;
      end
      S_NR_SQ: begin
        cmd.op    = wgs_pkg::OP_SQ;
        cmd.src   = wgs_pkg::SRC_REP;
        state_nxt = S_NR_ACC;
      end
      S_NR_ACC: begin
        cmd.op    = wgs_pkg::OP_ACC;
        idx_nxt   = last ? 2'd0 : idx_r + 2'd1;
        state_nxt = last ? S_REP_CMP : S_NR_SQ;
      end
      S_REP_CMP: begin
        cmd.op    = wgs_pkg::OP_REP_CMP;
        state_nxt = S_DF_SUB;
      end
      // arrival test on distance and speed
      S_DF_SUB: begin
        cmd.op    = wgs_pkg::OP_DIFF;
        state_nxt = S_DF_SQ;
      end
      S_DF_SQ: begin
        cmd.op    = wgs_pkg::OP_SQ;
        cmd.src   = wgs_pkg::SRC_TMP;
        state_nxt = S_DF_ACC;
      end
      S_DF_ACC: begin
        cmd.op    = wgs_pkg::OP_ACC;
        idx_nxt   = last ? 2'd0 : idx_r + 2'd1;
        state_nxt = last ? S_DF_SAVE : S_DF_SUB;
      end
      S_DF_SAVE: begin
        cmd.op    = wgs_pkg::OP_SAVE;
        state_nxt = S_NV_SQ;
      end
      S_NV_SQ: begin
        cmd.op    = wgs_pkg::OP_SQ;
        cmd.src   = wgs_pkg::SRC_VEL;
        state_nxt = S_NV_ACC;
      end
      S_NV_ACC: begin
        cmd.op    = wgs_pkg::OP_ACC;
        idx_nxt   = last ? 2'd0 : idx_r + 2'd1;
        state_nxt = last ? S_AR_SQ : S_NV_SQ;
      end
      S_AR_SQ: begin
        cmd.op    = wgs_pkg::OP_SQ;
        cmd.src   = wgs_pkg::SRC_AR;
        state_nxt = S_ARR;
      end
      S_ARR: begin
        cmd.op    = wgs_pkg::OP_ARR;
        state_nxt = S_BR;
      end
      S_BR: state_nxt = stat.arrived ? S_IV_MUL : S_ER_SUB;
      // steering error and its length
      S_ER_SUB: begin
        cmd.op    = wgs_pkg::OP_ERR;
        state_nxt = S_ER_SQ;
      end
      S_ER_SQ: begin
        cmd.op    = wgs_pkg::OP_SQ;
        cmd.src   = wgs_pkg::SRC_TMP;
        state_nxt = S_ER_ACC;
      end
      S_ER_ACC: begin
        cmd.op    = wgs_pkg::OP_ACC;
        idx_nxt   = last ? 2'd0 : idx_r + 2'd1;
        state_nxt = last ? S_SQ_GO : S_ER_SUB;
      end
      S_SQ_GO: begin
        cmd.op    = wgs_pkg::OP_SQRT_GO;
        state_nxt = S_SQ_WAIT;
      end
      S_SQ_WAIT: if (stat.sqrt_done) state_nxt = S_SQ_SET;
      S_SQ_SET: begin
        cmd.op    = wgs_pkg::OP_SQRT_SET;
        state_nxt = S_NZ;
      end
      S_NZ: state_nxt = stat.n_zero ? S_IV_MUL : S_AC_MUL;
      // rescale error to max_accel
      S_AC_MUL: begin
        cmd.op    = wgs_pkg::OP_AC_MUL;
        state_nxt = S_AC_GO;
      end
      S_AC_GO: begin
        cmd.op    = wgs_pkg::OP_AC_GO;
        state_nxt = S_AC_WAIT;
      end
      S_AC_WAIT: if (stat.div_done) state_nxt = S_AC_SET;
      S_AC_SET: begin
        cmd.op    = wgs_pkg::OP_AC_SET;
        idx_nxt   = last ? 2'd0 : idx_r + 2'd1;
        state_nxt = last ? S_IV_MUL : S_AC_MUL;
      end
      // integrate velocity then position
      S_IV_MUL: begin
        cmd.op    = wgs_pkg::OP_IV_MUL;
        state_nxt = S_IV_UPD;
      end
      S_IV_UPD: begin
        cmd.op    = wgs_pkg::OP_IV_UPD;
        state_nxt = S_IP_MUL;
      end
      S_IP_MUL: begin
        cmd.op    = wgs_pkg::OP_IP_MUL;
        state_nxt = S_IP_UPD;
      end
      S_IP_UPD: begin
        cmd.op    = wgs_pkg::OP_IP_UPD;
        idx_nxt   = last ? 2'd0 : idx_r + 2'd1;
        state_nxt = last ? S_OUT : S_IV_MUL;
      end
      // hold until the output register is free
      S_OUT: begin
        if (!(out_valid_r && out_stall)) begin
          cmd.op        = wgs_pkg::OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  a_accept_starts : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_DEN))
    else $error("accepted beat did not start a step");

  a_idx_range : assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= wgs_pkg::LAST_IDX)
    else $error("axis index out of range");

  a_out_from_final : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("result beat raised outside the final state");

  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_valid_r && out_stall) |=> (state_r == S_OUT))
    else $error("pending result beat overwritten");

endmodule

`default_nettype wire

>>> sv/waypoint_guidance_step.sv
// Waypoint guidance step: each accepted beat carries one time step dt and
// returns one result beat with the new position, the applied acceleration
// and the arrival flag; position and acceleration are signed Q16.16 with
// saturation. A step takes longest when steering, less when the steering
// error is zero and least once arrived. The cost is set by the shared
// bit-serial divider, used once per axis for the braking vector and once
// per axis for the acceleration rescale, plus a bit-serial square root
// unit for the error length. The input stays stalled for the whole step. A
// new step is taken while the previous result still waits on the output
// register; the step then holds in its final cycle until that beat is taken.
`default_nettype none

module waypoint_guidance_step (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [16:0]        in_step_dt,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_pos_x,
  output logic signed [31:0]      out_pos_y,
  output logic signed [31:0]      out_pos_z,
  output logic signed [31:0]      out_acc_x,
  output logic signed [31:0]      out_acc_y,
  output logic signed [31:0]      out_acc_z,
  output logic                    out_arrived,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  wgs_pkg::dp_cmd_t  cmd;
  wgs_pkg::dp_stat_t stat;

  wgs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  wgs_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_step_dt  (in_step_dt),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_pos_x   (out_pos_x),
    .out_pos_y   (out_pos_y),
    .out_pos_z   (out_pos_z),
    .out_acc_x   (out_acc_x),
    .out_acc_y   (out_acc_y),
    .out_acc_z   (out_acc_z),
    .out_arrived (out_arrived)
  );

endmodule

`default_nettype wire

>>> verif/wgs_checker.sv
`default_nettype none

module wgs_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [16:0]        in_step_dt,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic signed [31:0] out_pos_x,
  input  wire logic signed [31:0] out_pos_y,
  input  wire logic signed [31:0] out_pos_z,
  input  wire logic signed [31:0] out_acc_x,
  input  wire logic signed [31:0] out_acc_y,
  input  wire logic signed [31:0] out_acc_z,
  input  wire logic               out_arrived,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  output int                      steps_pending,
  output int                      fail_count
);

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] acc;
    logic             arrived;
  } step_result_t;

  // guidance state mirrored from the block
  logic signed [31:0] tgt [3];
  logic [30:0]        accel_lim;
  logic [30:0]        radius;
  logic signed [31:0] pos [3];
  logic signed [31:0] vel [3];
  logic signed [31:0] rep [3];

  step_result_t expected_steps [$];

  function automatic logic [31:0] abs_val(input logic signed [31:0] v);
    return v < 0 ? 32'd0 - v : v;
  endfunction

  // attach a sign to a magnitude and clamp to 32 bits
  function automatic logic signed [31:0] apply_sign(input logic neg, input logic [63:0] m);
    if (neg) return (m >= 64'h8000_0000) ? 32'sh8000_0000 : -$signed({1'b0, m[30:0]});
    return (m > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(m[31:0]);
  endfunction

  function automatic logic signed [31:0] clamp(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] sum_sq(input logic signed [31:0] a, b, c);
    logic [63:0] ma, mb, mc;
    ma = {32'd0, abs_val(a)};
    mb = {32'd0, abs_val(b)};
    mc = {32'd0, abs_val(c)};
    return ma * ma + mb * mb + mc * mc;
  endfunction

  function automatic logic [63:0] floor_root(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] scale_dt(input logic signed [31:0] x,
                                                  input logic [16:0] dt);
    logic [63:0] p;
    p = ({32'd0, abs_val(x)} * {47'd0, dt}) >> 16;
    return apply_sign(x < 0, p);
  endfunction

  // advance the mirrored point mass by one step
  function automatic step_result_t advance_step(input logic [16:0] dt);
    step_result_t r;
    logic [63:0] den, m, r2, n;
    logic signed [31:0] brk [3];
    logic signed [31:0] dif [3];
    logic signed [31:0] err [3];
    logic signed [31:0] acc [3];
    logic hit;
    den = {33'd0, accel_lim} * {47'd0, dt};
    for (int i = 0; i < 3; i++) begin
      m = {32'd0, abs_val(vel[i])};
      if (m == 0) brk[i] = 0;
      else if (den == 0) brk[i] = apply_sign(vel[i] < 0, '1);
      else brk[i] = apply_sign(vel[i] < 0, (m << 32) / den);
    end
    if (sum_sq(brk[0], brk[1], brk[2]) > sum_sq(rep[0], rep[1], rep[2]))
      for (int i = 0; i < 3; i++) rep[i] = brk[i];
    for (int i = 0; i < 3; i++) dif[i] = clamp(longint'(tgt[i]) - longint'(pos[i]));
    r2 = {33'd0, radius} * {33'd0, radius};
    hit = sum_sq(dif[0], dif[1], dif[2]) < r2 && sum_sq(vel[0], vel[1], vel[2]) < r2;
    if (hit) begin
      for (int i = 0; i < 3; i++) begin
        rep[i] = 0;
        acc[i] = 0;
      end
    end else begin
      for (int i = 0; i < 3; i++)
        err[i] = clamp(longint'(tgt[i]) - longint'(pos[i]) - longint'(rep[i]));
      n = floor_root(sum_sq(err[0], err[1], err[2]));
      for (int i = 0; i < 3; i++)
        acc[i] = (n == 0) ? 32'sd0 :
                 apply_sign(err[i] < 0, {32'd0, abs_val(err[i])} * {33'd0, accel_lim} / n);
    end
    for (int i = 0; i < 3; i++) begin
      vel[i] = clamp(longint'(vel[i]) + longint'(scale_dt(acc[i], dt)));
      pos[i] = clamp(longint'(pos[i]) + longint'(scale_dt(vel[i], dt)));
      r.pos[i] = pos[i];
      r.acc[i] = acc[i];
    end
    r.arrived = hit;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s expected %0d got %0d", name, $signed(exp_v), $signed(got_v));
      fail_count++;
    end
  endtask

  // track config, predict on input beats, compare on result beats
  always @(posedge clk) begin
    step_result_t e;
    if (!rst_n) begin
      tgt[0] = wgs_pkg::RST_TARGET_X;
      tgt[1] = wgs_pkg::RST_TARGET_Y;
      tgt[2] = wgs_pkg::RST_TARGET_Z;
      accel_lim = wgs_pkg::RST_MAX_ACCEL;
      radius = wgs_pkg::RST_ARRIVE_RAD;
      for (int i = 0; i < 3; i++) begin
        pos[i] = 0;
        vel[i] = 0;
        rep[i] = 0;
      end
      expected_steps.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          wgs_pkg::CFG_TARGET_X:   tgt[0] = cfg_data;
          wgs_pkg::CFG_TARGET_Y:   tgt[1] = cfg_data;
          wgs_pkg::CFG_TARGET_Z:   tgt[2] = cfg_data;
          wgs_pkg::CFG_MAX_ACCEL:  accel_lim = cfg_data[30:0];
          wgs_pkg::CFG_ARRIVE_RAD: radius = cfg_data[30:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_steps.size() == 0) begin
          $error("result beat with no step pending");
          fail_count++;
        end else begin
          e = expected_steps.pop_front();
          check_field("pos_x", e.pos[0], out_pos_x);
          check_field("pos_y", e.pos[1], out_pos_y);
          check_field("pos_z", e.pos[2], out_pos_z);
          check_field("acc_x", e.acc[0], out_acc_x);
          check_field("acc_y", e.acc[1], out_acc_y);
          check_field("acc_z", e.acc[2], out_acc_z);
          check_field("arrived", {31'd0, e.arrived}, {31'd0, out_arrived});
        end
      end
      if (in_valid && !in_stall) expected_steps.push_back(advance_step(in_step_dt));
    end
    steps_pending = expected_steps.size();
  end

  initial fail_count = 0;

endmodule

`default_nettype wire

>>> verif/tb_waypoint_guidance_step.sv
`default_nettype none

module tb_waypoint_guidance_step;

  localparam int STALL_LIMIT = 20000;
  localparam int LONG_HOLD = 2500;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [16:0]        in_step_dt = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [31:0] out_acc_x, out_acc_y, out_acc_z;
  logic               out_arrived;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  int                 steps_pending;
  int                 fail_count;

  logic no_gaps = 1'b0;
  logic hold_req = 1'b0;
  int   quiet_cycles = 0;

  always #4 clk = ~clk;

  waypoint_guidance_step u_dut (.*);

  wgs_checker u_chk (.*);

  // abort when the channels stop moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_waypoint_guidance_step: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stall before each beat unless no_gaps is set, one long hold-off on request
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      n = no_gaps ? 0 : $urandom_range(0, 10);
      if (hold_req) begin
        hold_req = 1'b0;
        n = LONG_HOLD;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_step(input logic [16:0] dt);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_step_dt <= dt;
    do @(posedge clk); while (in_stall);
  endtask

  // drop valid and wait for the block to drain
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (steps_pending != 0) @(posedge clk);
  endtask

  task automatic write_regs(input logic [31:0] tx, ty, tz, input logic [30:0] ma, ar);
    logic [2:0] idx [6];
    logic [31:0] val [6];
    idx = '{wgs_pkg::CFG_TARGET_X, wgs_pkg::CFG_TARGET_Y, wgs_pkg::CFG_TARGET_Z,
            wgs_pkg::CFG_MAX_ACCEL, wgs_pkg::CFG_ARRIVE_RAD,
            3'($urandom_range(5, 7))};
    val = '{tx, ty, tz, {1'($urandom), ma}, {1'($urandom), ar}, $urandom};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [16:0] pick_dt();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 17'($urandom_range(1, 65536));
    if (r < 85) return 17'($urandom_range(1, 256));
    if (r < 95) return 17'($urandom);
    return 17'd65536;
  endfunction

  function automatic logic [31:0] pick_target();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 32'($signed($urandom_range(0, 6553600)) - 32'sd3276800);
    if (r < 7) return $urandom;
    if (r == 7) return 32'h7FFF_FFFF;
    if (r == 8) return 32'h8000_0000;
    return 32'd0;
  endfunction

  function automatic logic [30:0] pick_accel();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 31'($urandom_range(16384, 3276800));
    if (r == 6) return 31'd1;
    if (r == 7) return 31'h7FFF_FFFF;
    if (r == 8) return 31'd0;
    return 31'($urandom);
  endfunction

  function automatic logic [30:0] pick_radius();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 31'($urandom_range(0, 3276800));
    if (r == 6) return 31'h7FFF_FFFF;
    if (r == 7) return 31'd0;
    return 31'($urandom);
  endfunction

  initial begin
    logic [16:0] directed [20];
    directed = '{17'd65536, 17'd1, 17'd0, 17'h1FFFF, 17'd32768, 17'd65535, 17'd65537,
                 17'd100000, 17'd2, 17'h0AAAA, 17'h15555, 17'd65536, 17'd65536,
                 17'd65536, 17'd16384, 17'd65536, 17'd65536, 17'd4096, 17'd65536, 17'd1};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed steps on the reset configuration
    foreach (directed[i]) send_step(directed[i]);
    drain();

    // fixed corner settings: arrive everywhere, far extremes, zero divisor, tiny accel
    write_regs(32'd0, 32'd0, 32'd0, 31'd655360, 31'h7FFF_FFFF);
    for (int i = 0; i < 15; i++) send_step(pick_dt());
    drain();
    write_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd0);
    for (int i = 0; i < 15; i++) send_step(pick_dt());
    drain();
    write_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 31'd0, 31'd0);
    for (int i = 0; i < 15; i++) send_step(pick_dt());
    drain();
    write_regs(32'd65536, 32'hFFFF_0000, 32'd0, 31'd1, 31'd1310720);
    for (int i = 0; i < 15; i++) send_step(pick_dt());
    drain();

    // random settings
    for (int ph = 0; ph < 11; ph++) begin
      write_regs(pick_target(), pick_target(), pick_target(), pick_accel(), pick_radius());
      no_gaps = (ph % 4 == 2);
      for (int i = 0; i < 33; i++) begin
        if (ph == 3 && i == 5) hold_req = 1'b1;
        if (ph == 5 && i == 16) drain();
        send_step(pick_dt());
      end
      drain();
    end
    no_gaps = 1'b0;

    repeat (600) @(posedge clk);
    if (fail_count == 0 && steps_pending == 0) begin
      $display("tb_waypoint_guidance_step: clean");
    end else begin
      $display("tb_waypoint_guidance_step: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
